// ----- rtl/core/swfd_pkg.sv -----
package swfd_pkg;

  // sync pair and error pattern bytes
  localparam logic [7:0] SYNC_HI   = 8'hAA;
  localparam logic [7:0] SYNC_LO   = 8'h55;
  localparam logic [7:0] ERR_MARK  = 8'h01;
  localparam logic [7:0] ERR_B_FF  = 8'hFF;
  localparam logic [7:0] ERR_B_10  = 8'h10;
  localparam logic [7:0] ERR_B_11  = 8'h11;

  // frame byte counter, saturating
  localparam int unsigned COUNT_W = 6;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_SYNC = 6'd2;

  // result kinds
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  // position after the sync pair
  localparam logic [1:0] POS_IDLE   = 2'd0;
  localparam logic [1:0] POS_THIRD  = 2'd1;
  localparam logic [1:0] POS_FOURTH = 2'd2;

  typedef enum logic [1:0] {
    ERR_FF = 2'd0,
    ERR_10 = 2'd1,
    ERR_11 = 2'd2
  } err_code_t;

  // command from the front to the back
  typedef struct packed {
    logic      is_frame;
    err_code_t code;
  } cmd_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_FETCH,
    B_SHOW
  } back_state_t;

endpackage

// ----- rtl/core/swfd_frame_store.sv -----
module swfd_frame_store import swfd_pkg::*; #(
  parameter int unsigned STORE_DEPTH = 32,
  parameter int unsigned AW = $clog2(STORE_DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/swfd_cmd_queue.sv -----
module swfd_cmd_queue import swfd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t       entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;

  // pointer and fill update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    fill_nxt   = fill_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign full       = fill_r[1];
  assign head_valid = (fill_r != 2'd0);
  assign head_cmd   = entry_r[rd_ptr_r];

endmodule

// ----- rtl/core/swfd_front.sv -----
module swfd_front import swfd_pkg::*; #(
  parameter int unsigned FRAME_LEN   = 21,
  parameter int unsigned STORE_DEPTH = 32,
  parameter int unsigned AW = $clog2(STORE_DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic          cfg_wr_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_rx_byte,
  output logic          q_push,
  output cmd_t          q_cmd,
  input  logic          q_full,
  input  logic          frame_done,
  output logic          st_wr_en,
  output logic [AW-1:0] st_wr_addr,
  output logic [7:0]    st_wr_data
);

  localparam bit FRAME_FITS = (FRAME_LEN <= STORE_DEPTH);
  localparam logic [COUNT_W-1:0] CLOSE_COUNT = COUNT_W'(FRAME_LEN + 1);
  localparam logic [COUNT_W:0]   DEPTH_LIM   = (COUNT_W + 1)'(STORE_DEPTH);

  logic               cap_en_r;
  logic [7:0]         prev_r, prev_nxt;
  logic               synced_r, synced_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [1:0]         pos_r, pos_nxt;
  logic               third_one_r, third_one_nxt;
  logic               pending_r, pending_nxt;
  logic               take;
  logic               is_sync;
  logic               err_hit;
  err_code_t          err_code;

  // stall while a frame drains from the store or the queue is full
  assign in_ready = !q_full && !pending_r;
  assign take     = in_valid && in_ready && cap_en_r;
  assign is_sync  = (prev_r == SYNC_HI) && (in_rx_byte == SYNC_LO);

  // error pattern decode on the fourth byte after sync
  always_comb begin
    err_hit  = 1'b0;
    err_code = ERR_FF;
    if (pos_r == POS_FOURTH && third_one_r) begin
      priority if (in_rx_byte == ERR_B_FF) begin
        err_hit  = 1'b1;
        err_code = ERR_FF;
      end else if (in_rx_byte == ERR_B_10) begin
        err_hit  = 1'b1;
        err_code = ERR_10;
      end else if (in_rx_byte == ERR_B_11) begin
        err_hit  = 1'b1;
        err_code = ERR_11;
      end else begin
        err_hit  = 1'b0;
      end
    end
  end

  // classify the item and update parser state
  always_comb begin
    prev_nxt      = prev_r;
    synced_nxt    = synced_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    third_one_nxt = third_one_r;
    pending_nxt   = pending_r && !frame_done;
    q_push        = 1'b0;
    q_cmd         = '{is_frame: 1'b0, code: err_code};
    st_wr_en      = 1'b0;
    st_wr_addr    = count_r[AW-1:0];
    st_wr_data    = in_rx_byte;
    if (take) begin
      prev_nxt = in_rx_byte;
      unique case (pos_r)
        POS_FOURTH: pos_nxt = POS_IDLE;
        POS_THIRD: begin
          pos_nxt       = POS_FOURTH;
          third_one_nxt = (in_rx_byte == ERR_MARK);
        end
        default: pos_nxt = POS_IDLE;
      endcase
      if (err_hit) begin
        q_push = 1'b1;
      end
      if (is_sync) begin
        // sync pair is never stored, the back supplies entries 0 and 1
        if (synced_r && count_r == CLOSE_COUNT && FRAME_FITS) begin
          q_push      = 1'b1;
          q_cmd       = '{is_frame: 1'b1, code: ERR_FF};
          pending_nxt = 1'b1;
        end
        synced_nxt    = 1'b1;
        count_nxt     = COUNT_SYNC;
        pos_nxt       = POS_THIRD;
        third_one_nxt = 1'b0;
      end else if (synced_r) begin
        st_wr_en = ({1'b0, count_r} < DEPTH_LIM);
        if (count_r != COUNT_MAX) begin
          count_nxt = count_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_en_r    <= 1'b1;
      prev_r      <= 8'h00;
      synced_r    <= 1'b0;
      count_r     <= '0;
      pos_r       <= POS_IDLE;
      third_one_r <= 1'b0;
      pending_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_en_r <= cfg_wr_data;
      end
      prev_r      <= prev_nxt;
      synced_r    <= synced_nxt;
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      third_one_r <= third_one_nxt;
      pending_r   <= pending_nxt;
    end
  end

endmodule

// ----- rtl/core/swfd_back.sv -----
module swfd_back import swfd_pkg::*; #(
  parameter int unsigned FRAME_LEN   = 21,
  parameter int unsigned STORE_DEPTH = 32,
  parameter int unsigned AW = $clog2(STORE_DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  cmd_t          q_cmd,
  output logic          q_pop,
  output logic          frame_done,
  output logic          st_rd_en,
  output logic [AW-1:0] st_rd_addr,
  input  logic [7:0]    st_rd_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_kind,
  output logic [7:0]    out_data_byte,
  output logic [1:0]    out_error_code,
  output logic          out_last
);

  localparam logic [AW-1:0] LAST_IDX = AW'(FRAME_LEN - 1);

  back_state_t   state_r, state_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          kind_r;
  logic [7:0]    data_r;
  err_code_t     code_r;
  logic          last_r;
  logic          slot_free;
  logic          load_err;
  logic          load_byte;
  logic          is_last;
  logic [7:0]    frame_byte;

  assign slot_free = !out_valid_r || out_ready;
  assign is_last   = (idx_r == LAST_IDX);

  // the sync pair heads every frame and is not kept in the store
  always_comb begin
    priority if (idx_r == AW'(0)) begin
      frame_byte = SYNC_HI;
    end else if (idx_r == AW'(1)) begin
      frame_byte = SYNC_LO;
    end else begin
      frame_byte = st_rd_data;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (q_valid && q_cmd.is_frame) begin
          state_nxt = B_FETCH;
        end
      end
      B_FETCH: state_nxt = B_SHOW;
      B_SHOW: begin
        if (slot_free) begin
          state_nxt = is_last ? B_IDLE : B_FETCH;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop      = 1'b0;
    load_err   = 1'b0;
    load_byte  = 1'b0;
    frame_done = 1'b0;
    st_rd_en   = 1'b0;
    st_rd_addr = idx_r;
    idx_nxt    = idx_r;
    unique case (state_r)
      B_IDLE: begin
        if (q_valid && q_cmd.is_frame) begin
          q_pop   = 1'b1;
          idx_nxt = '0;
        end else if (q_valid && slot_free) begin
          q_pop    = 1'b1;
          load_err = 1'b1;
        end
      end
      B_FETCH: st_rd_en = 1'b1;
      B_SHOW: begin
        if (slot_free) begin
          load_byte  = 1'b1;
          frame_done = is_last;
          idx_nxt    = idx_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = load_err || load_byte || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output register and frame index
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (load_err) begin
      kind_r <= KIND_ERROR;
      data_r <= 8'h00;
      code_r <= q_cmd.code;
      last_r <= 1'b1;
    end else if (load_byte) begin
      kind_r <= KIND_FRAME;
      data_r <= frame_byte;
      code_r <= ERR_FF;
      last_r <= is_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = kind_r;
  assign out_data_byte  = data_r;
  assign out_error_code = code_r;
  assign out_last       = last_r;

endmodule

// ----- rtl/core/sync_word_frame_deframer_top.sv -----
// channel   direction  handshake                 payload
// in        input      in_valid / in_ready       in_rx_byte
// out       output     out_valid / out_ready     out_kind out_data_byte out_error_code out_last
// cfg       input      cfg_wr_en                 cfg_wr_data (capture enable)
//
// an input item is taken on in_valid and in_ready; the item that closes a good frame
// holds in_ready low until the frame is drained, each frame byte going through a store
// read and then the output register
// error reports pass through the command queue and then the output register
// reset is synchronous on rst_n low; capture comes up enabled, no sync seen
// a stalled output holds the back end; the front keeps taking items until
// the two-entry command queue fills
module sync_word_frame_deframer_top import swfd_pkg::*; #(
  parameter int unsigned FRAME_LEN   = 21,
  parameter int unsigned STORE_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_kind,
  output logic [7:0] out_data_byte,
  output logic [1:0] out_error_code,
  output logic       out_last
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);

  logic          q_push;
  cmd_t          q_push_cmd;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  cmd_t          q_head;
  logic          frame_done;
  logic          st_wr_en;
  logic [AW-1:0] st_wr_addr;
  logic [7:0]    st_wr_data;
  logic          st_rd_en;
  logic [AW-1:0] st_rd_addr;
  logic [7:0]    st_rd_data;

  // parser and classifier
  swfd_front #(
    .FRAME_LEN   (FRAME_LEN),
    .STORE_DEPTH (STORE_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_rx_byte  (in_rx_byte),
    .q_push      (q_push),
    .q_cmd       (q_push_cmd),
    .q_full      (q_full),
    .frame_done  (frame_done),
    .st_wr_en    (st_wr_en),
    .st_wr_addr  (st_wr_addr),
    .st_wr_data  (st_wr_data)
  );

  // command queue between front and back
  swfd_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_head)
  );

  // frame byte buffer
  swfd_frame_store #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .rd_en   (st_rd_en),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  // result sequencer
  swfd_back #(
    .FRAME_LEN   (FRAME_LEN),
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_cmd          (q_head),
    .q_pop          (q_pop),
    .frame_done     (frame_done),
    .st_rd_en       (st_rd_en),
    .st_rd_addr     (st_rd_addr),
    .st_rd_data     (st_rd_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_data_byte  (out_data_byte),
    .out_error_code (out_error_code),
    .out_last       (out_last)
  );

endmodule
